/* rtl/core/cpc_pkg.sv */
// Shared types and constants for the Cartesian/polar converter.
// No dependencies; every other file in the block imports this package.
package cpc_pkg;

  // Fixed widths of the item fields
  localparam int unsigned IN_W = 16;
  localparam int unsigned RA_W = 17;
  localparam int unsigned RB_W = 16;

  // Angle accumulator: 30 fractional bits plus room for +-(pi + sum of atan)
  localparam int unsigned ZW        = 35;
  localparam int unsigned TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;

  // Reciprocal of the CORDIC gain, Q30, and its two 15-bit halves
  localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;
  localparam logic signed [15:0] INV_GAIN_LO  = {1'b0, INV_GAIN_Q30[14:0]};
  localparam logic signed [15:0] INV_GAIN_HI  = {1'b0, INV_GAIN_Q30[29:15]};

  // Angle limits in 13 fractional bits
  localparam logic signed [IN_W-1:0] THETA_LIMIT = 16'sd25735;
  localparam logic signed [17:0]     ANGLE_MAX   = 18'sd25736;

  // Saturation bounds of the results
  localparam int RA_MAX = 65535;
  localparam int RA_MIN = -65536;
  localparam int RB_MAX = 32767;
  localparam int RB_MIN = -32768;

  // floor(atan(2^-i) * 2^30)
  localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic mode;   // 0: vectoring (Cartesian to polar), 1: rotation
    logic bad;    // invalid polar request
    logic zero;   // zero vector in vectoring mode
  } cpc_ctrl_t;

endpackage

/* rtl/core/cpc_in_if.sv */
// Input channel of the converter: valid/ready plus one request item.
// Depends on cpc_pkg for the field widths.
interface cpc_in_if import cpc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic signed [IN_W-1:0] operand_a;
  logic signed [IN_W-1:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

/* rtl/core/cpc_out_if.sv */
// Output channel of the converter: valid/ready plus one result item.
// Depends on cpc_pkg for the field widths.
interface cpc_out_if import cpc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [RA_W-1:0] result_a;
  logic signed [RB_W-1:0] result_b;
  logic                   bad_polar;

  modport source (output valid, result_a, result_b, bad_polar, input ready);
  modport sink   (input valid, result_a, result_b, bad_polar, output ready);
endinterface

/* rtl/core/cpc_prep.sv */
// Two-stage front end: input scaling, gain pre-multiply, request checks,
// quadrant folding. Produces the start vector and angle for the cell row.
// Depends on cpc_pkg.
module cpc_prep import cpc_pkg::*; #(
  parameter int unsigned DW = 16,
  parameter int unsigned XW = 19
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic                   req_type_i,
  input  logic signed [IN_W-1:0] operand_a_i,
  input  logic signed [IN_W-1:0] operand_b_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output cpc_ctrl_t              ctrl_o,
  output logic signed [XW-1:0]   x_o,
  output logic signed [XW-1:0]   y_o,
  output logic signed [ZW-1:0]   z_o
);

  localparam int unsigned SL = (DW >= IN_W) ? DW - IN_W : 0;
  localparam int unsigned SR = (DW < IN_W) ? IN_W - DW : 0;
  localparam int unsigned PW = DW + 31;
  localparam logic signed [PW-1:0] RND_P = PW'(1) <<< 29;

  // Stage A registers
  logic                 a_valid_q;
  cpc_ctrl_t            a_ctrl_q;
  logic                 a_neg_q, b_neg_q;
  logic signed [DW-1:0] as_q, bs_q;
  logic signed [ZW-1:0] bz_q;
  logic signed [PW-1:0] prod_q;

  // Stage A next values
  logic                 a_ready;
  cpc_ctrl_t            a_ctrl_d;
  logic signed [31:0]   a_w, b_w;
  logic signed [DW-1:0] as_d, bs_d;
  logic signed [ZW-1:0] bz_d;
  logic signed [PW-1:0] prod_d;

  // Stage B registers and next values
  logic                 b_valid_q;
  logic                 b_ready;
  cpc_ctrl_t            b_ctrl_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic signed [PW-1:0] rnd_p;
  logic signed [XW-1:0] x0, xa, ya;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  // Scale inputs, check the request, start the gain multiply
  always_comb begin
    a_w    = (32'(operand_a_i) <<< SL) >>> SR;
    b_w    = (32'(operand_b_i) <<< SL) >>> SR;
    as_d   = a_w[DW-1:0];
    bs_d   = b_w[DW-1:0];
    bz_d   = ZW'(operand_b_i) <<< 17;
    prod_d = as_d * INV_GAIN_Q30;
    a_ctrl_d.mode = req_type_i;
    a_ctrl_d.bad  = req_type_i && (operand_a_i[IN_W-1] || (operand_b_i > THETA_LIMIT) ||
                                   (operand_b_i < -THETA_LIMIT));
    a_ctrl_d.zero = !req_type_i && (operand_a_i == '0) && (operand_b_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_ctrl_q <= a_ctrl_d;
      a_neg_q  <= operand_a_i[IN_W-1];
      b_neg_q  <= operand_b_i[IN_W-1];
      as_q     <= as_d;
      bs_q     <= bs_d;
      bz_q     <= bz_d;
      prod_q   <= prod_d;
    end
  end

  // Fold the start vector: half turn for vectoring, quarter turn for rotation
  always_comb begin
    rnd_p = (prod_q + RND_P) >>> 30;
    x0    = rnd_p[XW-1:0];
    xa    = XW'(as_q);
    ya    = XW'(bs_q);
    x_d   = xa;
    y_d   = ya;
    z_d   = '0;
    if (a_ctrl_q.mode) begin
      priority if (bz_q > HALF_PI_Q30) begin
        x_d = '0;
        y_d = x0;
        z_d = bz_q - HALF_PI_Q30;
      end else if (bz_q < -HALF_PI_Q30) begin
        x_d = '0;
        y_d = -x0;
        z_d = bz_q + HALF_PI_Q30;
      end else begin
        x_d = x0;
        y_d = '0;
        z_d = bz_q;
      end
    end else if (a_neg_q) begin
      x_d = -xa;
      y_d = -ya;
      z_d = b_neg_q ? -PI_Q30 : PI_Q30;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_ctrl_q <= a_ctrl_q;
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
    end
  end

  assign valid_o = b_valid_q;
  assign ctrl_o  = b_ctrl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

/* rtl/core/cpc_cell.sv */
// One CORDIC micro-rotation cell with its own pipeline register.
// STAGE sets the shift and the arctangent constant. Depends on cpc_pkg.
module cpc_cell import cpc_pkg::*; #(
  parameter int unsigned XW    = 19,
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  cpc_ctrl_t            ctrl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cpc_ctrl_t            ctrl_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ATAN_C = ZW'(ATAN_Q30[STAGE]);

  logic                 valid_q;
  cpc_ctrl_t            ctrl_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d;
  logic                 ccw;

  assign ready_o = !valid_q || ready_i;

  // Rotate toward y = 0 (vectoring) or z = 0 (rotation)
  always_comb begin
    ccw = ctrl_i.mode ? !z_i[ZW-1] : y_i[XW-1];
    xs  = x_i >>> STAGE;
    ys  = y_i >>> STAGE;
    if (ccw) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN_C;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN_C;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q <= ctrl_i;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

`ifndef SYNTH
  // A stalled item stays in its cell unchanged
  a_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(x_q) && $stable(y_q) && $stable(z_q))
    else $error("cell lost or changed a stalled item");
`endif

endmodule

/* rtl/core/cpc_post.sv */
// Back end: gain removal for vectoring (split multiply over two stages),
// rounding to 13 fractional bits, saturation, and the output register.
// Depends on cpc_pkg.
module cpc_post import cpc_pkg::*; #(
  parameter int unsigned DW = 16,
  parameter int unsigned XW = 19
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  cpc_ctrl_t              ctrl_i,
  input  logic signed [XW-1:0]   x_i,
  input  logic signed [XW-1:0]   y_i,
  input  logic signed [ZW-1:0]   z_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic signed [RA_W-1:0] result_a_o,
  output logic signed [RB_W-1:0] result_b_o,
  output logic                   bad_polar_o
);

  localparam int unsigned SW  = XW + 4;
  localparam int unsigned SRO = (DW > IN_W) ? DW - IN_W : 0;
  localparam int unsigned SLO = (DW < IN_W) ? IN_W - DW : 0;
  localparam logic signed [SW-1:0] RND_O = (SRO == 0) ? '0 : (SW'(1) <<< (SRO - 1));
  localparam int unsigned MW  = XW + 16;
  localparam int unsigned QW  = XW + 32;
  localparam int unsigned S   = DW + 14;
  localparam logic signed [QW-1:0] RND_V = QW'(1) <<< (S - 1);
  localparam logic signed [ZW-1:0] RND_Z = ZW'(1) <<< 16;

  // Stage 1
  logic                   v1_q;
  cpc_ctrl_t              ctrl1_q;
  logic signed [MW-1:0]   plo_q, phi_q;
  logic signed [RB_W-1:0] ang_q, ang_d;
  logic signed [RA_W-1:0] rra_q, rra_d;
  logic signed [RB_W-1:0] rrb_q, rrb_d;
  logic signed [ZW-1:0]   zr;
  logic signed [SW-1:0]   xo, yo;
  logic                   ready1;

  // Output register
  logic                   out_valid_q;
  logic signed [RA_W-1:0] ra_q, ra_d;
  logic signed [RB_W-1:0] rb_q, rb_d;
  logic                   bad_q;
  logic signed [QW-1:0]   psum, vr;

  assign ready1  = !out_valid_q || ready_i;
  assign ready_o = !v1_q || ready1;

  // Round the angle and the rotated coordinates, start the gain multiply
  always_comb begin
    zr = (z_i + RND_Z) >>> 17;
    priority if (zr > ZW'(ANGLE_MAX)) begin
      ang_d = RB_W'(ANGLE_MAX);
    end else if (zr < -ZW'(ANGLE_MAX)) begin
      ang_d = -RB_W'(ANGLE_MAX);
    end else begin
      ang_d = zr[RB_W-1:0];
    end
    xo = ((SW'(x_i) + RND_O) >>> SRO) <<< SLO;
    yo = ((SW'(y_i) + RND_O) >>> SRO) <<< SLO;
    priority if (xo > SW'(RA_MAX)) begin
      rra_d = RA_W'(RA_MAX);
    end else if (xo < SW'(RA_MIN)) begin
      rra_d = RA_W'(RA_MIN);
    end else begin
      rra_d = xo[RA_W-1:0];
    end
    priority if (yo > SW'(RB_MAX)) begin
      rrb_d = RB_W'(RB_MAX);
    end else if (yo < SW'(RB_MIN)) begin
      rrb_d = RB_W'(RB_MIN);
    end else begin
      rrb_d = yo[RB_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready_o) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl1_q <= ctrl_i;
      plo_q   <= x_i * INV_GAIN_LO;
      phi_q   <= x_i * INV_GAIN_HI;
      ang_q   <= ang_d;
      rra_q   <= rra_d;
      rrb_q   <= rrb_d;
    end
  end

  // Finish the magnitude and pick the result for this request
  always_comb begin
    psum  = (QW'(phi_q) <<< 15) + QW'(plo_q) + RND_V;
    vr    = psum >>> S;
    ra_d  = '0;
    rb_d  = '0;
    priority if (ctrl1_q.bad || ctrl1_q.zero) begin
      ra_d = '0;
      rb_d = '0;
    end else if (ctrl1_q.mode) begin
      ra_d = rra_q;
      rb_d = rrb_q;
    end else begin
      priority if (vr > QW'(RA_MAX)) begin
        ra_d = RA_W'(RA_MAX);
      end else if (vr < QW'(RA_MIN)) begin
        ra_d = RA_W'(RA_MIN);
      end else begin
        ra_d = vr[RA_W-1:0];
      end
      rb_d = ang_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready1) begin
      out_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && v1_q) begin
      ra_q  <= ra_d;
      rb_q  <= rb_d;
      bad_q <= ctrl1_q.bad;
    end
  end

  assign valid_o     = out_valid_q;
  assign result_a_o  = ra_q;
  assign result_b_o  = rb_q;
  assign bad_polar_o = bad_q;

`ifndef SYNTH
  // An invalid polar request leaves zero results
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && bad_q |-> (ra_q == '0) && (rb_q == '0))
    else $error("flagged item carries nonzero results");

  // A zero vector gives zero magnitude and angle, no flag
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && ready1 && ctrl1_q.zero |=> (ra_q == '0) && (rb_q == '0) && !bad_q)
    else $error("zero vector gave a nonzero result");

  // A vectoring angle stays within +-pi
  a_angle_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && ready1 && !ctrl1_q.mode && !ctrl1_q.zero |=>
      (18'(rb_q) <= ANGLE_MAX) && (18'(rb_q) >= -ANGLE_MAX))
    else $error("angle beyond pi");
`endif

endmodule

/* rtl/core/cartesian_polar_converter.sv */
// Top level of the Cartesian/polar converter: front end, row of CORDIC
// cells, back end. Depends on cpc_pkg, cpc_in_if, cpc_out_if and the cpc_* modules.
//
// Each item is one conversion: req_type 0 turns (x, y) into magnitude and
// angle in [-pi, pi], req_type 1 turns (r, theta) into (x, y); all values
// carry 13 fractional bits, and an invalid polar request returns zeros with
// bad_polar set. The block takes one item per clock cycle unless the output
// stalls it, and returns one result per item, in order. Its stages: two
// front-end stages (input scaling with the gain multiply, then quadrant
// folding), one cell per CORDIC step, one stage for rounding and the split
// gain multiply of the magnitude, and the output register. Every stage has
// its own valid bit, so empty slots fill while a result waits at the output.
module cartesian_polar_converter import cpc_pkg::*; #(
  parameter int unsigned ITERATIONS = 16,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpc_in_if.sink    in_i,
  cpc_out_if.source out_o
);

  localparam int unsigned XW = DATA_WIDTH + 3;

  logic                 cv [ITERATIONS+1];
  logic                 cr [ITERATIONS+1];
  cpc_ctrl_t            cc [ITERATIONS+1];
  logic signed [XW-1:0] cx [ITERATIONS+1];
  logic signed [XW-1:0] cy [ITERATIONS+1];
  logic signed [ZW-1:0] cz [ITERATIONS+1];

  // Scale, check and fold each request
  cpc_prep #(
    .DW (DATA_WIDTH),
    .XW (XW)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .req_type_i  (in_i.req_type),
    .operand_a_i (in_i.operand_a),
    .operand_b_i (in_i.operand_b),
    .valid_o     (cv[0]),
    .ready_i     (cr[0]),
    .ctrl_o      (cc[0]),
    .x_o         (cx[0]),
    .y_o         (cy[0]),
    .z_o         (cz[0])
  );

  // One cell per CORDIC step
  for (genvar gi = 0; gi < ITERATIONS; gi++) begin : g_cell
    cpc_cell #(
      .XW    (XW),
      .STAGE (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[gi]),
      .ready_o (cr[gi]),
      .ctrl_i  (cc[gi]),
      .x_i     (cx[gi]),
      .y_i     (cy[gi]),
      .z_i     (cz[gi]),
      .valid_o (cv[gi+1]),
      .ready_i (cr[gi+1]),
      .ctrl_o  (cc[gi+1]),
      .x_o     (cx[gi+1]),
      .y_o     (cy[gi+1]),
      .z_o     (cz[gi+1])
    );
  end

  // Remove the gain, round, saturate and hold the result item
  cpc_post #(
    .DW (DATA_WIDTH),
    .XW (XW)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cv[ITERATIONS]),
    .ready_o     (cr[ITERATIONS]),
    .ctrl_i      (cc[ITERATIONS]),
    .x_i         (cx[ITERATIONS]),
    .y_i         (cy[ITERATIONS]),
    .z_i         (cz[ITERATIONS]),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .result_a_o  (out_o.result_a),
    .result_b_o  (out_o.result_b),
    .bad_polar_o (out_o.bad_polar)
  );

endmodule
